// ===== sv/escape_sequence_decoder_core_macros.svh =====
// assertion macros for the escape sequence decoder
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH
`ifndef SYNTH
`define ESD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("esd assertion failed");
`define ESD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esd implication failed");
`else
`define ESD_ASSERT(lbl, clk, rst_n, prop)
`define ESD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/esd_pkg.sv =====
// types, constants and decode functions shared by the escape sequence decoder
`default_nettype none
package esd_pkg;

    localparam int MAX_LEN   = 16;
    localparam int ESD_CNT_W = $clog2(MAX_LEN + 1);
    localparam int ESD_HELD  = 3;
    localparam int ESD_WIN   = ESD_HELD + 1;

    localparam logic [ESD_CNT_W-1:0] ESD_MAX_CNT = ESD_CNT_W'(MAX_LEN);

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty_req;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic       status;
    } t_res;

    typedef struct packed {
        logic [ESD_WIN-1:0][7:0] bytes;
        logic [2:0]              nbytes;
        logic                    done;
        logic                    status;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [2:0] cons;
        logic [7:0] val;
    } t_cls;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // characters consumed (zero means wait for more) and the decoded byte
    function automatic t_cls classify(input logic [ESD_WIN-1:0][7:0] w,
                                      input logic [2:0] n, input logic fin);
        t_cls r;
        r.cons = 3'd1;
        r.val  = CH_BSLASH;
        if (w[0] != CH_BSLASH) begin
            r.val = w[0];
        end else if (n < 3'd2) begin
            r.cons = fin ? 3'd1 : 3'd0;
        end else if (w[1] == CH_BSLASH) begin
            r.cons = 3'd2;
        end else if (w[1] == CH_X) begin
            if (n >= 3'd3 && !is_hex(w[2])) begin
                r.cons = 3'd1;
            end else if (n < 3'd4) begin
                r.cons = fin ? 3'd1 : 3'd0;
            end else if (!is_hex(w[3])) begin
                r.cons = 3'd1;
            end else begin
                r.val  = {hex_val(w[2]), hex_val(w[3])};
                r.cons = 3'd4;
            end
        end else if (is_oct(w[1])) begin
            if (n >= 3'd3 && !is_oct(w[2])) begin
                r.cons = 3'd1;
            end else if (n < 3'd4) begin
                r.cons = fin ? 3'd1 : 3'd0;
            end else if (!is_oct(w[3])) begin
                r.cons = 3'd1;
            end else begin
                r.val  = {w[1][1:0], w[2][2:0], w[3][2:0]};
                r.cons = 3'd4;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/esd_front.sv =====
// front end: takes characters, decodes the lookahead window and queues result bundles
`default_nettype none
`include "escape_sequence_decoder_core_macros.svh"
module esd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  esd_pkg::t_in_item   i_item,
    output logic                o_stall,
    input  esd_pkg::t_q_status  i_q_stat,
    output logic                o_push,
    output esd_pkg::t_bundle    o_bundle
);
    import esd_pkg::*;

    logic [ESD_HELD-1:0][7:0] r_held, n_held;
    logic [1:0]               r_held_count, n_held_count;
    logic [ESD_CNT_W-1:0]     r_bytes_out, n_bytes_out;
    logic                     r_overflowed, n_overflowed;

    logic                     accept;
    logic                     fin;
    logic [ESD_WIN-1:0][7:0]  wv;
    logic [2:0]               rem;
    logic [ESD_CNT_W-1:0]     cnt;
    logic                     ovf;
    logic                     halt;
    logic [2:0]               nb;
    t_cls                     cls;
    t_bundle                  bundle;

    assign accept  = i_valid && !i_q_stat.full;
    assign o_stall = i_q_stat.full;

    always_comb begin
        fin    = i_item.empty_req || i_item.last;
        wv     = {8'h00, r_held};
        rem    = {1'b0, r_held_count};
        cnt    = r_bytes_out;
        ovf    = r_overflowed;
        halt   = 1'b0;
        nb     = 3'd0;
        cls    = '0;
        bundle = '0;
        if (!i_item.empty_req) begin
            wv[r_held_count] = i_item.ch;
            rem = rem + 3'd1;
        end
        for (int it = 0; it < ESD_WIN; it++) begin
            if (!halt && rem != 3'd0) begin
                if (ovf) begin
                    rem  = 3'd0;
                    halt = 1'b1;
                end else if (cnt >= ESD_MAX_CNT) begin
                    ovf  = 1'b1;
                    rem  = 3'd0;
                    halt = 1'b1;
                end else begin
                    cls = classify(wv, rem, fin);
                    if (cls.cons == 3'd0) begin
                        halt = 1'b1;
                    end else begin
                        bundle.bytes[nb[1:0]] = cls.val;
                        nb  = nb + 3'd1;
                        cnt = cnt + ESD_CNT_W'(1);
                        wv  = wv >> {cls.cons, 3'b000};
                        rem = rem - cls.cons;
                    end
                end
            end
        end
        bundle.nbytes = nb;
        bundle.done   = fin;
        bundle.status = fin && ovf;

        n_held       = r_held;
        n_held_count = r_held_count;
        n_bytes_out  = r_bytes_out;
        n_overflowed = r_overflowed;
        if (accept) begin
            if (fin) begin
                n_held       = '0;
                n_held_count = 2'd0;
                n_bytes_out  = '0;
                n_overflowed = 1'b0;
            end else begin
                n_held       = wv[ESD_HELD-1:0];
                n_held_count = rem[1:0];
                n_bytes_out  = cnt;
                n_overflowed = ovf;
            end
        end
    end

    assign o_push   = accept && (nb != 3'd0 || fin);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_count <= 2'd0;
            r_bytes_out  <= '0;
            r_overflowed <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_held_count <= n_held_count;
            r_bytes_out  <= n_bytes_out;
            r_overflowed <= n_overflowed;
        end
    end

    `ESD_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_bytes_out <= ESD_MAX_CNT)
    `ESD_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, r_overflowed, r_bytes_out == ESD_MAX_CNT)
    `ESD_ASSERT_IMP(a_ovf_nothing_held, i_clk, i_rst_n, r_overflowed, r_held_count == 2'd0)

endmodule
`default_nettype wire

// ===== sv/esd_queue.sv =====
// two-entry bundle queue between the front and back ends
`default_nettype none
`include "escape_sequence_decoder_core_macros.svh"
module esd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  esd_pkg::t_bundle    i_bundle,
    input  wire                 i_pop,
    output esd_pkg::t_bundle    o_head,
    output esd_pkg::t_q_status  o_stat
);
    import esd_pkg::*;

    t_bundle    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_head     = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ESD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= 2'd2)
    `ESD_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, r_count != 2'd2)
    `ESD_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != 2'd0)

endmodule
`default_nettype wire

// ===== sv/esd_back.sv =====
// back end: unpacks each bundle into results through the output register
`default_nettype none
module esd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  esd_pkg::t_bundle    i_head,
    input  esd_pkg::t_q_status  i_q_stat,
    output logic                o_pop,
    output logic                o_valid,
    output esd_pkg::t_res       o_res,
    input  wire                 i_stall
);
    import esd_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_res       r_res, n_res;
    logic       load;
    logic [2:0] total;

    assign total = i_head.nbytes + {2'b00, i_head.done};
    assign load  = (!r_valid || !i_stall) && !i_q_stat.empty;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && i_stall;
        n_res   = r_res;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (r_idx < i_head.nbytes) begin
                n_res.out_byte   = i_head.bytes[r_idx[1:0]];
                n_res.byte_valid = 1'b1;
                n_res.done_res   = 1'b0;
                n_res.status     = 1'b0;
            end else begin
                n_res.out_byte   = 8'h00;
                n_res.byte_valid = 1'b0;
                n_res.done_res   = 1'b1;
                n_res.status     = i_head.status;
            end
            if (r_idx + 3'd1 == total) begin
                o_pop = 1'b1;
                n_idx = 3'd0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ===== sv/escape_sequence_decoder_core.sv =====
// path: a request's results pass through the two-entry bundle queue and then the output register
// throughput: one request a cycle while the two-entry bundle queue has room
// each request yields zero to five results, sent one a cycle from the output register while i_stall is low
// the output port's one result a cycle, while i_stall is low, sets the sustained rate for busy strings
// reset: synchronous, active low, clears lookahead, counters, queue and output valid
`default_nettype none
module escape_sequence_decoder_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  esd_pkg::t_in_item  i_item,
    output logic               o_stall,
    output logic               o_valid,
    output esd_pkg::t_res      o_res,
    input  wire                i_stall
);
    import esd_pkg::*;

    logic      push;
    logic      pop;
    t_bundle   bundle;
    t_bundle   head;
    t_q_status q_stat;

    esd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .o_stall  (o_stall),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_bundle (bundle)
    );

    esd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (q_stat)
    );

    esd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_res    (o_res),
        .i_stall  (i_stall)
    );

endmodule
`default_nettype wire

// ===== sim/escape_sequence_decoder_core_tb.sv =====
// self-checking testbench for the escape sequence decoder: directed table, random strings
`timescale 1ns / 1ps
`default_nettype none
module escape_sequence_decoder_core_tb;
    import esd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 60;
    localparam int TAIL_CYCLES    = 10;
    localparam int RANDOM_ITEMS   = 140;

    typedef struct {
        t_in_item item;
        int       n_typed;
        t_res     r0;
        t_res     r1;
    } t_dir_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    t_in_item i_item;
    logic     o_stall;
    logic     o_valid;
    t_res     o_res;
    logic     i_stall;

    t_dir_row        directed_rows[$];
    t_in_item        string_chars[$];
    t_res            char_res[$];
    t_res            awaited_res[$];

    logic [3:0][7:0] held_w;
    int              held_n;
    int              bytes_emitted;
    bit              overflowed;

    int              tx_pct;
    int              rx_pct;
    bit              hold_go;
    int              errors;
    int              requests_taken;
    int              results_seen;
    int              overflow_strings;
    int              idle_cycles;

    escape_sequence_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_res   (o_res),
        .i_stall (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_res mk_res(input logic [7:0] b, input logic v, input logic d,
                                    input logic s);
        t_res r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.done_res   = d;
        r.status     = s;
        return r;
    endfunction

    function automatic t_in_item mk_item(input logic [7:0] c, input logic l, input logic e);
        t_in_item it;
        it.ch        = c;
        it.last      = l;
        it.empty_req = e;
        return it;
    endfunction

    function automatic bit oct_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h37;
    endfunction

    function automatic bit hex_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        if (c <= 8'h39) begin
            return 4'(c - 8'h30);
        end else if (c >= 8'h61) begin
            return 4'(c - 8'h61 + 8'd10);
        end
        return 4'(c - 8'h41 + 8'd10);
    endfunction

    // characters taken by the escape at the head of the window, zero to wait
    function automatic int escape_len(input logic [3:0][7:0] w, input int n, input bit fin,
                                      output logic [7:0] val);
        int v;
        val = CH_BSLASH;
        if (w[0] != CH_BSLASH) begin
            val = w[0];
            return 1;
        end
        if (n < 2) return fin ? 1 : 0;
        if (w[1] == CH_BSLASH) return 2;
        if (w[1] == CH_X) begin
            if (n >= 3 && !hex_digit(w[2])) return 1;
            if (n < 4) return fin ? 1 : 0;
            if (!hex_digit(w[3])) return 1;
            val = {nibble(w[2]), nibble(w[3])};
            return 4;
        end
        if (oct_digit(w[1])) begin
            if (n >= 3 && !oct_digit(w[2])) return 1;
            if (n < 4) return fin ? 1 : 0;
            if (!oct_digit(w[3])) return 1;
            v = (int'(w[1]) - 48) * 64 + (int'(w[2]) - 48) * 8 + (int'(w[3]) - 48);
            val = 8'(v & 255);
            return 4;
        end
        return 1;
    endfunction

    task automatic decode_char(input t_in_item it);
        logic [3:0][7:0] w;
        logic [7:0]      val;
        int              n;
        int              used;
        bit              fin;
        char_res.delete();
        w = held_w;
        n = held_n;
        if (it.empty_req) begin
            fin = 1'b1;
        end else begin
            w[n] = it.ch;
            n++;
            fin = it.last;
        end
        while (n > 0) begin
            if (overflowed) begin
                n = 0;
                break;
            end
            if (bytes_emitted >= MAX_LEN) begin
                overflowed = 1'b1;
                n = 0;
                break;
            end
            used = escape_len(w, n, fin, val);
            if (used == 0) break;
            char_res.push_back(mk_res(val, 1'b1, 1'b0, 1'b0));
            bytes_emitted++;
            w = w >> (8 * used);
            n -= used;
        end
        held_w = w;
        held_n = (n > 3) ? 3 : n;
        if (fin) begin
            char_res.push_back(mk_res(8'h00, 1'b0, 1'b1, overflowed));
            held_w        = '0;
            held_n        = 0;
            bytes_emitted = 0;
            overflowed    = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("%0t mismatch on %s: got %02h, expected %02h", $time, what, got, want);
        errors++;
    endtask

    // drive one request, wait for it to be taken, then book its results
    task automatic offer(input t_in_item it, input int n_typed, input t_res r0, input t_res r1);
        while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_char(it);
        if (n_typed < 0) begin
            foreach (char_res[k]) awaited_res.push_back(char_res[k]);
        end else begin
            if (n_typed > 0) awaited_res.push_back(r0);
            if (n_typed > 1) awaited_res.push_back(r1);
        end
        requests_taken++;
    endtask

    function automatic logic [7:0] hex_char(input int d);
        if (d < 10) return 8'(8'h30 + d);
        if (d < 16) return 8'(8'h61 + d - 10);
        return 8'(8'h41 + d - 16);
    endfunction

    // mostly well-formed escapes with random content, some broken ones and noise
    task automatic send_string();
        int target;
        int kind;
        string_chars.delete();
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 10);
        if ($urandom_range(0, 19) != 0) begin
            while (string_chars.size() < target) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    string_chars.push_back(mk_item(8'($urandom_range(1, 255)), 1'b0, 1'b0));
                end else if (kind < 45) begin
                    string_chars.push_back(mk_item(CH_BSLASH, 1'b0, 1'b0));
                    string_chars.push_back(mk_item(CH_BSLASH, 1'b0, 1'b0));
                end else if (kind < 65) begin
                    string_chars.push_back(mk_item(CH_BSLASH, 1'b0, 1'b0));
                    string_chars.push_back(mk_item(CH_X, 1'b0, 1'b0));
                    string_chars.push_back(mk_item(hex_char($urandom_range(0, 21)), 1'b0, 1'b0));
                    string_chars.push_back(mk_item(hex_char($urandom_range(0, 21)), 1'b0, 1'b0));
                end else if (kind < 80) begin
                    string_chars.push_back(mk_item(CH_BSLASH, 1'b0, 1'b0));
                    repeat (3) begin
                        string_chars.push_back(mk_item(8'(8'h30 + $urandom_range(0, 7)),
                                                       1'b0, 1'b0));
                    end
                end else if (kind < 90) begin
                    string_chars.push_back(mk_item(CH_BSLASH, 1'b0, 1'b0));
                    case ($urandom_range(0, 2))
                        0: string_chars.push_back(mk_item(CH_X, 1'b0, 1'b0));
                        1: string_chars.push_back(mk_item(8'(8'h30 + $urandom_range(0, 7)),
                                                          1'b0, 1'b0));
                        default: ;
                    endcase
                    string_chars.push_back(mk_item(8'($urandom_range(1, 255)), 1'b0, 1'b0));
                end else begin
                    string_chars.push_back(mk_item(8'($urandom_range(32, 126)), 1'b0, 1'b0));
                end
            end
        end
        if (string_chars.size() != 0 && $urandom_range(0, 99) < 85) begin
            string_chars[string_chars.size() - 1].last = 1'b1;
        end else begin
            string_chars.push_back(mk_item(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)),
                                           1'b1));
        end
        foreach (string_chars[k]) offer(string_chars[k], -1, '0, '0);
    endtask

    // receiver side: random stall, or a long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_go = 1'b0;
            end
            i_stall <= (rx_pct != 0) && ($urandom_range(0, 99) < rx_pct);
        end
    end

    always @(posedge i_clk) begin : res_check
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_res.size() == 0) begin
                flag_mismatch("unexpected result", o_res.out_byte, 8'h00);
            end else begin
                want = awaited_res.pop_front();
                if (o_res.out_byte !== want.out_byte)
                    flag_mismatch("out_byte", o_res.out_byte, want.out_byte);
                if (o_res.byte_valid !== want.byte_valid)
                    flag_mismatch("byte_valid", 8'(o_res.byte_valid), 8'(want.byte_valid));
                if (o_res.done_res !== want.done_res)
                    flag_mismatch("done_res", 8'(o_res.done_res), 8'(want.done_res));
                if (o_res.status !== want.status)
                    flag_mismatch("status", 8'(o_res.status), 8'(want.status));
                results_seen++;
                if (want.done_res && want.status) overflow_strings++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_item           <= '0;
        idle_cycles      = 0;
        tx_pct           = 0;
        rx_pct           = 0;
        hold_go          = 1'b0;
        errors           = 0;
        requests_taken   = 0;
        results_seen     = 0;
        overflow_strings = 0;
        held_w           = '0;
        held_n           = 0;
        bytes_emitted    = 0;
        overflowed       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty string, single plain character
        directed_rows.push_back('{mk_item(8'h00, 1'b0, 1'b1), 1,
                                  mk_res(8'h00, 1'b0, 1'b1, 1'b0), '0});
        directed_rows.push_back('{mk_item(8'h41, 1'b1, 1'b0), 2,
                                  mk_res(8'h41, 1'b1, 1'b0, 1'b0),
                                  mk_res(8'h00, 1'b0, 1'b1, 1'b0)});
        // double backslash
        directed_rows.push_back('{mk_item(CH_BSLASH, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(CH_BSLASH, 1'b1, 1'b0), -1, '0, '0});
        // hex escape
        directed_rows.push_back('{mk_item(CH_BSLASH, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(CH_X, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(8'h34, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(8'h46, 1'b1, 1'b0), -1, '0, '0});
        // octal escape beyond 8 bits
        directed_rows.push_back('{mk_item(CH_BSLASH, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(8'h37, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(8'h37, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(8'h37, 1'b1, 1'b0), -1, '0, '0});
        // unknown escape is literal
        directed_rows.push_back('{mk_item(CH_BSLASH, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(8'h71, 1'b1, 1'b0), -1, '0, '0});
        // escape cut short by the end of the string
        directed_rows.push_back('{mk_item(CH_BSLASH, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(CH_X, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(8'h34, 1'b1, 1'b0), -1, '0, '0});
        // empty request while characters are held
        directed_rows.push_back('{mk_item(CH_BSLASH, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(CH_X, 1'b0, 1'b0), -1, '0, '0});
        directed_rows.push_back('{mk_item(8'h80, 1'b1, 1'b1), -1, '0, '0});
        // character extremes and the zero character
        directed_rows.push_back('{mk_item(8'hff, 1'b0, 1'b0), 1,
                                  mk_res(8'hff, 1'b1, 1'b0, 1'b0), '0});
        directed_rows.push_back('{mk_item(8'h00, 1'b0, 1'b0), 1,
                                  mk_res(8'h00, 1'b1, 1'b0, 1'b0), '0});
        directed_rows.push_back('{mk_item(8'h01, 1'b1, 1'b0), 2,
                                  mk_res(8'h01, 1'b1, 1'b0, 1'b0),
                                  mk_res(8'h00, 1'b0, 1'b1, 1'b0)});
        foreach (directed_rows[k]) begin
            offer(directed_rows[k].item, directed_rows[k].n_typed,
                  directed_rows[k].r0, directed_rows[k].r1);
        end

        // receiver holds off while the sender keeps going, string overflows too
        hold_go = 1'b1;
        for (int k = 0; k < 20; k++) begin
            offer(mk_item(8'($urandom_range(1, 255)), 1'(k == 19), 1'b0), -1, '0, '0);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 58; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 58; end
                default: begin tx_pct = 25; rx_pct = 25; end
            endcase
            while (requests_taken < directed_rows.size() + 20 +
                   (RANDOM_ITEMS * (phase + 1)) / 4) begin
                send_string();
            end
        end
        i_valid <= 1'b0;

        while (awaited_res.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d checked results", requests_taken, results_seen);
        $display("strings ending in overflow: %0d", overflow_strings);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
